// ===== src/srqe_pkg.sv =====
package srqe_pkg;

    localparam int DIV_STAGES = 32;
    localparam int NUM_W      = 63;
    localparam int DEN_W      = 31;
    localparam int LANES      = 4;

    localparam logic [1:0] CORNER_BR = 2'd3;

    typedef enum logic [2:0] {
        REG_CLIP_X      = 3'd0,
        REG_CLIP_Y      = 3'd1,
        REG_CLIP_WIDTH  = 3'd2,
        REG_CLIP_HEIGHT = 3'd3,
        REG_CLIP_ENABLE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [30:0] w;
        logic [30:0] h;
        logic [31:0] u1;
        logic [31:0] v1;
        logic [31:0] u2;
        logic [31:0] v2;
        logic [31:0] color;
    } t_sprite;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [30:0] w;
        logic [30:0] h;
        logic        en;
    } t_cfg;

    // lane order: u left, u right, v top, v bottom
    typedef struct packed {
        logic        reject;
        logic [31:0] x_lo;
        logic [31:0] x_hi;
        logic [31:0] y_lo;
        logic [31:0] y_hi;
        logic [31:0] u1;
        logic [31:0] u2;
        logic [31:0] v1;
        logic [31:0] v2;
        logic [3:0]  neg;
        logic [31:0] color;
    } t_side;

endpackage

// ===== src/srqe_front.sv =====
module srqe_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  srqe_pkg::t_sprite           i_sprite,
    input  srqe_pkg::t_cfg              i_cfg,
    output logic                        o_valid,
    output srqe_pkg::t_side             o_side,
    output logic [srqe_pkg::NUM_W-1:0]  o_num [srqe_pkg::LANES],
    output logic [srqe_pkg::DEN_W-1:0]  o_den [srqe_pkg::LANES]
);

    localparam logic signed [32:0] MAX33 = 33'sh0_7FFF_FFFF;

    // stage 1: edges and spans
    logic              r_s1_v;
    srqe_pkg::t_sprite r_s1_s;
    logic signed [32:0] r_s1_x2, r_s1_y2, r_s1_cx2, r_s1_cy2, r_s1_spx, r_s1_spy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
        end
        if (i_en) begin
            r_s1_s   <= i_sprite;
            r_s1_x2  <= $signed({i_sprite.x[31], i_sprite.x})
                      + $signed({2'b00, i_sprite.w});
            r_s1_y2  <= $signed({i_sprite.y[31], i_sprite.y})
                      + $signed({2'b00, i_sprite.h});
            r_s1_cx2 <= $signed({i_cfg.x[31], i_cfg.x}) + $signed({2'b00, i_cfg.w});
            r_s1_cy2 <= $signed({i_cfg.y[31], i_cfg.y}) + $signed({2'b00, i_cfg.h});
            r_s1_spx <= $signed({i_sprite.u2[31], i_sprite.u2})
                      - $signed({i_sprite.u1[31], i_sprite.u1});
            r_s1_spy <= $signed({i_sprite.v2[31], i_sprite.v2})
                      - $signed({i_sprite.v1[31], i_sprite.v1});
        end
    end

    // stage 2: cull, trim decisions, clipped positions
    logic signed [32:0] xe, ye, cxe, cye, dx, dy, ex, ey, hx, hy, nspx, nspy;
    logic               tl, tr, tt, tb, rej;
    srqe_pkg::t_side    n_s2_side;

    always_comb begin
        xe   = $signed({r_s1_s.x[31], r_s1_s.x});
        ye   = $signed({r_s1_s.y[31], r_s1_s.y});
        cxe  = $signed({i_cfg.x[31], i_cfg.x});
        cye  = $signed({i_cfg.y[31], i_cfg.y});
        rej  = i_cfg.en && (r_s1_x2 < cxe || xe > r_s1_cx2
                            || r_s1_y2 < cye || ye > r_s1_cy2);
        tl   = i_cfg.en && (xe < cxe) && (r_s1_s.w != '0);
        tr   = i_cfg.en && (r_s1_x2 > r_s1_cx2) && (r_s1_s.w != '0);
        tt   = i_cfg.en && (ye < cye) && (r_s1_s.h != '0);
        tb   = i_cfg.en && (r_s1_y2 > r_s1_cy2) && (r_s1_s.h != '0);
        dx   = cxe - xe;
        dy   = cye - ye;
        ex   = r_s1_x2 - r_s1_cx2;
        ey   = r_s1_y2 - r_s1_cy2;
        hx   = tr ? r_s1_cx2 : r_s1_x2;
        hy   = tb ? r_s1_cy2 : r_s1_y2;
        nspx = -r_s1_spx;
        nspy = -r_s1_spy;
        n_s2_side.reject = rej;
        n_s2_side.x_lo   = tl ? i_cfg.x : r_s1_s.x;
        n_s2_side.y_lo   = tt ? i_cfg.y : r_s1_s.y;
        n_s2_side.x_hi   = (hx > MAX33) ? 32'h7FFF_FFFF : hx[31:0];
        n_s2_side.y_hi   = (hy > MAX33) ? 32'h7FFF_FFFF : hy[31:0];
        n_s2_side.u1     = r_s1_s.u1;
        n_s2_side.u2     = r_s1_s.u2;
        n_s2_side.v1     = r_s1_s.v1;
        n_s2_side.v2     = r_s1_s.v2;
        n_s2_side.neg    = {r_s1_spy[32], r_s1_spy[32], r_s1_spx[32], r_s1_spx[32]};
        n_s2_side.color  = r_s1_s.color;
    end

    logic                        r_s2_v;
    srqe_pkg::t_side             r_s2_side;
    logic [31:0]                 r_s2_mag [2];
    logic [srqe_pkg::DEN_W-1:0]  r_s2_d   [srqe_pkg::LANES];
    logic [srqe_pkg::DEN_W-1:0]  r_s2_den [srqe_pkg::LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (i_en) begin
            r_s2_v <= r_s1_v;
        end
        if (i_en) begin
            r_s2_side   <= n_s2_side;
            r_s2_mag[0] <= r_s1_spx[32] ? nspx[31:0] : r_s1_spx[31:0];
            r_s2_mag[1] <= r_s1_spy[32] ? nspy[31:0] : r_s1_spy[31:0];
            r_s2_d[0]   <= tl ? dx[30:0] : '0;
            r_s2_d[1]   <= tr ? ex[30:0] : '0;
            r_s2_d[2]   <= tt ? dy[30:0] : '0;
            r_s2_d[3]   <= tb ? ey[30:0] : '0;
            r_s2_den[0] <= tl ? r_s1_s.w : 31'd1;
            r_s2_den[1] <= tr ? r_s1_s.w : 31'd1;
            r_s2_den[2] <= tt ? r_s1_s.h : 31'd1;
            r_s2_den[3] <= tb ? r_s1_s.h : 31'd1;
        end
    end

    // stage 3: span times trim distance
    logic r_s3_v;
    srqe_pkg::t_side r_s3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (i_en) begin
            r_s3_v <= r_s2_v;
        end
        if (i_en) begin
            r_s3_side <= r_s2_side;
        end
    end

    for (genvar g = 0; g < srqe_pkg::LANES; g++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                o_num[g] <= {31'd0, r_s2_mag[g / 2]} * {32'd0, r_s2_d[g]};
                o_den[g] <= r_s2_den[g];
            end
        end
    end

    assign o_valid = r_s3_v;
    assign o_side  = r_s3_side;

endmodule

// ===== src/srqe_div.sv =====
module srqe_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [srqe_pkg::NUM_W-1:0] i_num,
    input  logic [srqe_pkg::DEN_W-1:0] i_den,
    output logic [31:0]                o_quo
);

    localparam int N = srqe_pkg::DIV_STAGES;

    logic [30:0] r_rem [N];
    logic [31:0] r_lq  [N];
    logic [30:0] r_den [N];
    logic [30:0] src_rem [N];
    logic [31:0] src_lq  [N];
    logic [30:0] src_den [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [31:0] t;
        logic [31:0] diff;
        logic        ge;

        if (g == 0) begin : g_first
            assign src_rem[g] = i_num[62:32];
            assign src_lq[g]  = i_num[31:0];
            assign src_den[g] = i_den;
        end else begin : g_next
            assign src_rem[g] = r_rem[g-1];
            assign src_lq[g]  = r_lq[g-1];
            assign src_den[g] = r_den[g-1];
        end

        assign t    = {src_rem[g], src_lq[g][31]};
        assign ge   = t >= {1'b0, src_den[g]};
        assign diff = t - {1'b0, src_den[g]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? diff[30:0] : t[30:0];
                r_lq[g]  <= {src_lq[g][30:0], ge};
                r_den[g] <= src_den[g];
            end
        end
    end

    assign o_quo = r_lq[N-1];

endmodule

// ===== src/srqe_emit.sv =====
module srqe_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  srqe_pkg::t_side      i_side,
    input  logic [31:0]          i_quo [srqe_pkg::LANES],
    input  logic                 i_ready,
    output logic                 o_take,
    output logic                 o_valid,
    output logic [159:0]         o_data,
    output logic [1:0]           o_corner,
    output logic                 o_last
);

    logic signed [32:0] qs [srqe_pkg::LANES];
    logic signed [32:0] u1f, u2f, v1f, v2f;

    for (genvar g = 0; g < srqe_pkg::LANES; g++) begin : g_sign
        assign qs[g] = i_side.neg[g] ? -$signed({1'b0, i_quo[g]}) : $signed({1'b0, i_quo[g]});
    end

    assign u1f = $signed({i_side.u1[31], i_side.u1}) + qs[0];
    assign u2f = $signed({i_side.u2[31], i_side.u2}) - qs[1];
    assign v1f = $signed({i_side.v1[31], i_side.v1}) + qs[2];
    assign v2f = $signed({i_side.v2[31], i_side.v2}) - qs[3];

    logic        r_busy;
    logic [1:0]  r_corner;
    logic [31:0] r_x [2];
    logic [31:0] r_y [2];
    logic [31:0] r_u [2];
    logic [31:0] r_v [2];
    logic [31:0] r_color;

    assign o_take = !r_busy || (i_ready && r_corner == srqe_pkg::CORNER_BR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_corner <= '0;
        end else if (o_take) begin
            r_busy   <= i_valid && !i_side.reject;
            r_corner <= '0;
        end else if (i_ready) begin
            r_corner <= r_corner + 2'd1;
        end
        if (o_take) begin
            r_x[0]  <= i_side.x_lo;
            r_x[1]  <= i_side.x_hi;
            r_y[0]  <= i_side.y_lo;
            r_y[1]  <= i_side.y_hi;
            r_u[0]  <= u1f[31:0];
            r_u[1]  <= u2f[31:0];
            r_v[0]  <= v1f[31:0];
            r_v[1]  <= v2f[31:0];
            r_color <= i_side.color;
        end
    end

    assign o_valid  = r_busy;
    assign o_corner = r_corner;
    assign o_last   = r_corner == srqe_pkg::CORNER_BR;
    assign o_data   = {r_color, r_v[r_corner[0]], r_u[r_corner[1]],
                       r_y[r_corner[0]], r_x[r_corner[1]]};

endmodule

// ===== src/sprite_rect_clip_quad_emit.sv =====
// channel   dir  beat payload
// s_axis    in   one sprite: x, y, width, height, u left, v top, u right, v bottom, color
// m_axis    out  one vertex: x, y, u, v, color; tuser corner; tlast on fourth vertex
// cfg       in   register write, no read-back
//
// a sprite beat reaches the first vertex through three front stages,
// 32 divider stages (one quotient bit each) and one output register
// a visible sprite occupies the single vertex port for its four vertices; a culled one emits none
// synchronous active-low reset clears valid bits, output state and clip registers
// the whole pipeline holds while a sprite at the last stage waits for the vertex
// port to finish the previous quad; s_tready falls only then
module sprite_rect_clip_quad_emit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // x, y, width, height, u left, v top, u right, v bottom, color, 2 pad bits
    input  logic [287:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // x, y, u, v, color
    output logic [159:0] o_m_tdata,
    // corner
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    localparam int N = srqe_pkg::DIV_STAGES;

    srqe_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (srqe_pkg::t_reg_idx'(i_cfg_addr))
                srqe_pkg::REG_CLIP_X:      r_cfg.x  <= i_cfg_wdata;
                srqe_pkg::REG_CLIP_Y:      r_cfg.y  <= i_cfg_wdata;
                srqe_pkg::REG_CLIP_WIDTH:  r_cfg.w  <= i_cfg_wdata[30:0];
                srqe_pkg::REG_CLIP_HEIGHT: r_cfg.h  <= i_cfg_wdata[30:0];
                srqe_pkg::REG_CLIP_ENABLE: r_cfg.en <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    srqe_pkg::t_sprite sprite;

    assign sprite.x     = i_s_tdata[31:0];
    assign sprite.y     = i_s_tdata[63:32];
    assign sprite.w     = i_s_tdata[94:64];
    assign sprite.h     = i_s_tdata[125:95];
    assign sprite.u1    = i_s_tdata[157:126];
    assign sprite.v1    = i_s_tdata[189:158];
    assign sprite.u2    = i_s_tdata[221:190];
    assign sprite.v2    = i_s_tdata[253:222];
    assign sprite.color = i_s_tdata[285:254];

    logic pipe_en;
    logic take;
    logic front_v;
    srqe_pkg::t_side front_side;
    logic [srqe_pkg::NUM_W-1:0] num [srqe_pkg::LANES];
    logic [srqe_pkg::DEN_W-1:0] den [srqe_pkg::LANES];
    logic [31:0] quo [srqe_pkg::LANES];

    logic            r_svld [N];
    srqe_pkg::t_side r_side [N];

    assign pipe_en    = !r_svld[N-1] || take;
    assign o_s_tready = pipe_en;

    srqe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (i_s_tvalid),
        .i_sprite (sprite),
        .i_cfg    (r_cfg),
        .o_valid  (front_v),
        .o_side   (front_side),
        .o_num    (num),
        .o_den    (den)
    );

    for (genvar g = 0; g < srqe_pkg::LANES; g++) begin : g_lane
        srqe_div u_div (
            .i_clk (i_clk),
            .i_en  (pipe_en),
            .i_num (num[g]),
            .i_den (den[g]),
            .o_quo (quo[g])
        );
    end

    // side data travels alongside the divider stages
    for (genvar g = 0; g < N; g++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svld[g] <= 1'b0;
            end else if (pipe_en) begin
                r_svld[g] <= (g == 0) ? front_v : r_svld[(g == 0) ? 0 : g-1];
            end
            if (pipe_en) begin
                r_side[g] <= (g == 0) ? front_side : r_side[(g == 0) ? 0 : g-1];
            end
        end
    end

    srqe_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_svld[N-1]),
        .i_side   (r_side[N-1]),
        .i_quo    (quo),
        .i_ready  (i_m_tready),
        .o_take   (take),
        .o_valid  (o_m_tvalid),
        .o_data   (o_m_tdata),
        .o_corner (o_m_tuser),
        .o_last   (o_m_tlast)
    );

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser == srqe_pkg::CORNER_BR)
        else $error("tlast off the bottom-right corner");

    a_hold_mid_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != srqe_pkg::CORNER_BR && r_svld[N-1] |-> !o_s_tready)
        else $error("pipeline advanced while a quad is still going out");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("vertex valid right after reset");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] color;
        logic [1:0]  corner;
        logic        last;
    } t_vertex;

    class quad_scoreboard;
        t_vertex expected_verts[$];
        int      mismatches;
        longint  cx, cy, cw, ch;
        bit      cen;

        function void set_reg(srqe_pkg::t_reg_idx idx, logic [31:0] val);
            case (idx)
                srqe_pkg::REG_CLIP_X:      cx = longint'(signed'(val));
                srqe_pkg::REG_CLIP_Y:      cy = longint'(signed'(val));
                srqe_pkg::REG_CLIP_WIDTH:  cw = longint'(val[30:0]);
                srqe_pkg::REG_CLIP_HEIGHT: ch = longint'(val[30:0]);
                srqe_pkg::REG_CLIP_ENABLE: cen = val[0];
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sh7fffffff) return 64'sh7fffffff;
            if (v < -64'sh80000000) return -64'sh80000000;
            return v;
        endfunction

        function void trim_axis(longint cmin, longint cmax, longint size,
                                inout longint lo, inout longint hi,
                                inout longint tlo, inout longint thi);
            longint span, near_e, far_e;
            span = thi - tlo;
            near_e = lo;
            far_e = hi;
            if (near_e < cmin && size > 0) begin
                tlo += (span * (cmin - near_e)) / size;
                lo = cmin;
            end
            if (far_e > cmax && size > 0) begin
                thi -= (span * (far_e - cmax)) / size;
                hi = cmax;
            end
        endfunction

        function void note_sprite(srqe_pkg::t_sprite s);
            longint x1, y1, x2, y2, u1, v1, u2, v2, w, h;
            t_vertex vt;
            x1 = longint'(signed'(s.x));
            y1 = longint'(signed'(s.y));
            w  = longint'(s.w);
            h  = longint'(s.h);
            u1 = longint'(signed'(s.u1));
            v1 = longint'(signed'(s.v1));
            u2 = longint'(signed'(s.u2));
            v2 = longint'(signed'(s.v2));
            x2 = x1 + w;
            y2 = y1 + h;
            if (cen) begin
                if (x2 < cx || x1 > cx + cw || y2 < cy || y1 > cy + ch) return;
                trim_axis(cx, cx + cw, w, x1, x2, u1, u2);
                trim_axis(cy, cy + ch, h, y1, y2, v1, v2);
            end
            x1 = sat32(x1);
            y1 = sat32(y1);
            x2 = sat32(x2);
            y2 = sat32(y2);
            for (int k = 0; k < 4; k++) begin
                vt.x = (k & 2) ? x2[31:0] : x1[31:0];
                vt.y = (k & 1) ? y2[31:0] : y1[31:0];
                vt.u = (k & 2) ? u2[31:0] : u1[31:0];
                vt.v = (k & 1) ? v2[31:0] : v1[31:0];
                vt.color = s.color;
                vt.corner = k[1:0];
                vt.last = (k == 3);
                expected_verts.push_back(vt);
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            mismatches++;
        endtask

        task check_vertex(t_vertex got);
            t_vertex e;
            if (expected_verts.size() == 0) begin
                report("unexpected vertex", got.x, 0);
                return;
            end
            e = expected_verts.pop_front();
            if (got.x !== e.x) report("x", got.x, e.x);
            if (got.y !== e.y) report("y", got.y, e.y);
            if (got.u !== e.u) report("u", got.u, e.u);
            if (got.v !== e.v) report("v", got.v, e.v);
            if (got.color !== e.color) report("color", got.color, e.color);
            if (got.corner !== e.corner) report("corner", got.corner, e.corner);
            if (got.last !== e.last) report("last", got.last, e.last);
        endtask
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [159:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we = 0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    quad_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    longint cycles;

    sprite_rect_clip_quad_emit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // vertex sink with random stall
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_vertex({m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                             m_tdata[127:96], m_tdata[159:128], m_tuser, m_tlast});
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task write_clip(logic [31:0] x, logic [31:0] y, logic [30:0] w, logic [30:0] h,
                    logic en);
        logic [31:0] vals[5];
        vals = '{x, y, {1'b0, w}, {1'b0, h}, {31'b0, en}};
        for (int i = 0; i < 5; i++) begin
            @(posedge i_clk);
            cfg_we <= 1;
            cfg_addr <= 3'(i);
            cfg_wdata <= vals[i];
            sb.set_reg(srqe_pkg::t_reg_idx'(i), vals[i]);
        end
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    task drain;
        while (sb.expected_verts.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task send_sprite(srqe_pkg::t_sprite s);
        if ($urandom_range(99) < send_idle_pct) begin
            @(posedge i_clk);
            s_tvalid <= 0;
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        @(posedge i_clk);
        s_tvalid <= 1;
        s_tdata <= {2'b0, s.color, s.v2, s.u2, s.v1, s.u1, s.h, s.w, s.y, s.x};
        do @(posedge i_clk); while (!s_tready);
        sb.note_sprite(s);
        s_tvalid <= 0;
    endtask

    task send_back_to_back(srqe_pkg::t_sprite s);
        s_tvalid <= 1;
        s_tdata <= {2'b0, s.color, s.v2, s.u2, s.v1, s.u1, s.h, s.w, s.y, s.x};
        do @(posedge i_clk); while (!s_tready);
        sb.note_sprite(s);
    endtask

    function srqe_pkg::t_sprite mk(logic [31:0] x, logic [31:0] y, logic [30:0] w,
                                   logic [30:0] h);
        srqe_pkg::t_sprite s;
        s.x = x;
        s.y = y;
        s.w = w;
        s.h = h;
        s.u1 = $urandom;
        s.v1 = $urandom;
        s.u2 = $urandom;
        s.v2 = $urandom;
        s.color = $urandom;
        return s;
    endfunction

    // mostly sprites around the clip window, some fully random
    function srqe_pkg::t_sprite rand_sprite();
        longint x, y;
        logic [30:0] w, h;
        if ($urandom_range(9) < 2)
            return mk($urandom, $urandom, 31'($urandom), 31'($urandom));
        w = 31'($urandom_range(0, 32'h0040_0000));
        h = 31'($urandom_range(0, 32'h0040_0000));
        x = sb.cx - longint'($urandom_range(0, 32'h0050_0000))
            + longint'($urandom_range(0, 32'h0060_0000));
        y = sb.cy - longint'($urandom_range(0, 32'h0050_0000))
            + longint'($urandom_range(0, 32'h0060_0000));
        return mk(x[31:0], y[31:0], w, h);
    endfunction

    task random_phase(int n, bit pause_mid);
        for (int i = 0; i < n; i++) begin
            send_sprite(rand_sprite());
            if (pause_mid && i == n / 2) drain();
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // directed
        write_clip(32'h0001_0000, 32'h0002_0000, 31'h0010_0000, 31'h0008_0000, 1);
        send_sprite(mk(32'h0000_0000, 32'h0000_0000, 31'h0020_0000, 31'h0020_0000));
        send_sprite(mk(32'h0004_0000, 32'h0004_0000, 31'h0002_0000, 31'h0002_0000));
        send_sprite(mk(32'h0000_0000, 32'h0004_0000, 31'h0000_ffff, 31'h0001_0000));
        send_sprite(mk(32'h0000_0000, 32'h0004_0000, 31'h0001_0000, 31'h0001_0000));
        send_sprite(mk(32'h0011_0000, 32'h0004_0000, 31'h0001_0000, 31'h0001_0000));
        send_sprite(mk(32'h0011_0001, 32'h0004_0000, 31'h0001_0000, 31'h0001_0000));
        send_sprite(mk(32'h0004_0000, 32'h0001_0000, 31'h0000_0000, 31'h0001_0000));
        send_sprite(mk(32'h0004_0000, 32'h000a_0001, 31'h0001_0000, 31'h0001_0000));
        send_sprite(mk(32'h0004_0000, 32'h0001_ffff, 31'h0001_0000, 31'h0000_0000));
        send_sprite(mk(32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 31'h7fff_ffff));
        send_sprite(mk(32'hffff_0000, 32'h0001_8000, 31'h0000_0000, 31'h0000_0000));
        drain();
        write_clip(32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 31'h0000_0000, 1);
        send_sprite(mk(32'h8000_0000, 32'h7fff_0000, 31'h7fff_ffff, 31'h0001_ffff));
        send_sprite(mk(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff));
        send_sprite(mk(32'h8000_0000, 32'h8000_0000, 31'h0000_0000, 31'h0000_0000));
        drain();
        write_clip(32'h7fff_ffff, 32'h8000_0000, 31'h0000_0000, 31'h7fff_ffff, 0);
        send_sprite(mk(32'h7fff_ffff, 32'h7fff_0000, 31'h7fff_ffff, 31'h0002_0000));
        send_sprite(mk(32'h8000_0000, 32'h0000_0000, 31'h0000_0000, 31'h7fff_ffff));
        @(posedge i_clk);
        send_back_to_back(mk(32'h1234_5678, 32'h8765_4321, 31'h0000_1000, 31'h0000_0100));
        send_back_to_back(mk(32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff, 31'h7fff_ffff));
        s_tvalid <= 0;
        drain();

        // random
        send_idle_pct = 34;
        recv_idle_pct = 51;
        write_clip($urandom, $urandom, 31'($urandom_range(0, 32'h0030_0000)),
                   31'($urandom_range(0, 32'h0030_0000)), 1);
        random_phase(70, 1);
        drain();
        send_idle_pct = 51;
        recv_idle_pct = 34;
        write_clip(32'h8000_0000, 32'hffff_0000, 31'h7fff_ffff, 31'h0010_0000, 1);
        random_phase(60, 0);
        @(posedge i_clk);
        for (int i = 0; i < 10; i++) send_back_to_back(rand_sprite());
        s_tvalid <= 0;
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_clip($urandom, $urandom, 31'($urandom), 31'($urandom), 0);
        for (int i = 0; i < 30; i++) send_back_to_back(rand_sprite());
        s_tvalid <= 0;
        drain();
        write_clip(32'h0000_0000, 32'h0000_0000, 31'h0020_0000, 31'h0020_0000, 1);
        for (int i = 0; i < 30; i++) send_back_to_back(rand_sprite());
        s_tvalid <= 0;
        drain();

        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
